@@ hdl/cnbc_pkg.sv @@
// Shared types and constants for the coverage new-bits checker.
// No dependencies; every other file of the block but cnbc_ram imports this package.
`timescale 1ns / 1ps

package cnbc_pkg;

    // Map geometry and data widths
    localparam int MAP_WORDS_DEF = 8192;
    localparam int COV_W         = 64;
    localparam int BYTE_W        = 8;
    localparam int COV_BYTES     = COV_W / BYTE_W;
    localparam int OUT_TDATA_W   = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [BYTE_W-1:0] PRISTINE_BYTE = 8'hff;

    // Verdict codes, ordered by strength
    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_NEW_BITS = 2'd1,
        VERDICT_NEW_BYTE = 2'd2
    } verdict_t;

    // One classified word handed from front to back
    typedef struct packed {
        verdict_t cls;
        logic     last;
    } cls_item_t;

    // Stronger of two verdicts
    function automatic verdict_t verdict_max(input verdict_t a, input verdict_t b);
        verdict_t r;
        r = (a > b) ? a : b;
        return r;
    endfunction

endpackage

@@ hdl/cnbc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cnbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/cnbc_front.sv @@
// Front part: accepts coverage words, reads and updates the virgin store, classifies.
// Depends on cnbc_pkg and cnbc_ram.
`timescale 1ns / 1ps

module cnbc_front
    import cnbc_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF,
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int FW = $clog2(MAP_WORDS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [COV_W-1:0] s_tdata,
    input  logic             s_tlast,
    output logic             push_valid,
    output cls_item_t        push_item,
    input  logic             push_ready
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(MAP_WORDS);

    logic [AW-1:0]    pos_reg, pos_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             p1_valid_reg, p1_valid_next;
    logic [COV_W-1:0] p1_cov_reg;
    logic             p1_last_reg;
    logic [AW-1:0]    p1_addr_reg;
    logic             byp_valid_reg, byp_valid_next;
    logic [COV_W-1:0] byp_data_reg;

    logic             accept;
    logic             p1_fire;
    logic [COV_W-1:0] ram_rd_data;
    logic [COV_W-1:0] vir;
    logic [COV_W-1:0] vir_new;
    logic             hit;
    logic             pristine;

    assign s_tready = !p1_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;
    assign p1_fire  = p1_valid_reg && push_ready;

    // Virgin store
    cnbc_ram #(
        .WIDTH (COV_W),
        .DEPTH (MAP_WORDS)
    ) u_virgin_ram (
        .clk     (aclk),
        .wr_en   (p1_fire),
        .wr_addr (p1_addr_reg),
        .wr_data (vir_new),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    // Pick the current virgin word: forwarded, stored, or never written (all ones)
    always_comb begin
        if (byp_valid_reg) begin
            vir = byp_data_reg;
        end else if ({{(FW-AW){1'b0}}, p1_addr_reg} < fill_reg) begin
            vir = ram_rd_data;
        end else begin
            vir = '1;
        end
    end

    // Classify the word against its virgin word
    always_comb begin
        pristine = 1'b0;
        for (int b = 0; b < COV_BYTES; b++) begin
            if ((p1_cov_reg[b*BYTE_W +: BYTE_W] != '0) &&
                (vir[b*BYTE_W +: BYTE_W] == PRISTINE_BYTE)) begin
                pristine = 1'b1;
            end
        end
        hit     = |(p1_cov_reg & vir);
        vir_new = vir & ~p1_cov_reg;
    end

    assign push_valid     = p1_valid_reg;
    assign push_item.last = p1_last_reg;
    assign push_item.cls  = !hit ? VERDICT_NONE :
                            (pristine ? VERDICT_NEW_BYTE : VERDICT_NEW_BITS);

    // Next-state logic for position, fill count, stage and forwarding
    always_comb begin
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        p1_valid_next  = p1_valid_reg;
        byp_valid_next = byp_valid_reg;
        if (accept) begin
            if (s_tlast || pos_reg == LAST_ADDR) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
            p1_valid_next  = 1'b1;
            byp_valid_next = p1_fire && (p1_addr_reg == pos_reg);
        end else if (p1_fire) begin
            p1_valid_next = 1'b0;
        end
        // Addresses are written in order from zero, so a count marks written words
        if (p1_fire && {{(FW-AW){1'b0}}, p1_addr_reg} == fill_reg && fill_reg != FILL_FULL) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            p1_valid_reg  <= p1_valid_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_cov_reg   <= s_tdata;
            p1_last_reg  <= s_tlast;
            p1_addr_reg  <= pos_reg;
            byp_data_reg <= vir_new;
        end
    end

endmodule

@@ hdl/cnbc_queue.sv @@
// Short queue of classified words between front and back.
// Depends on cnbc_pkg.
`timescale 1ns / 1ps

module cnbc_queue
    import cnbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    input  cls_item_t push_item,
    output logic      push_ready,
    output logic      pop_valid,
    output cls_item_t pop_item,
    input  logic      pop_ready
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cls_item_t        slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != QCW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/cnbc_back.sv @@
// Back part: folds word classes into the run verdict and emits it on the last word.
// Depends on cnbc_pkg.
`timescale 1ns / 1ps

module cnbc_back
    import cnbc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    input  cls_item_t              pop_item,
    output logic                   pop_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    verdict_t run_reg, run_next;
    verdict_t out_reg;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;
    logic     pop;
    verdict_t merged;

    assign out_free  = !out_valid_reg || m_tready;
    assign pop_ready = !pop_item.last || out_free;
    assign pop       = pop_valid && pop_ready;
    assign merged    = verdict_max(run_reg, pop_item.cls);

    // Accumulate and release the run verdict
    always_comb begin
        run_next       = run_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop) begin
            if (pop_item.last) begin
                run_next       = VERDICT_NONE;
                out_valid_next = 1'b1;
            end else begin
                run_next = merged;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg       <= VERDICT_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (pop && pop_item.last) begin
            out_reg <= merged;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_reg};

endmodule

@@ hdl/coverage_new_bits_check.sv @@
// Coverage new-bits checker. Takes one 64-bit coverage word per cycle, sustained, in map
// order with tlast on the final word of a run while results are taken, and returns one
// verdict per run (0 nothing new, 1 new hit counts, 2 new bytes touched). The verdict
// passes the front stage register, the queue and the output register to m_tvalid. The
// rate is set by the virgin store RAM, which gives one read and one write each cycle; a
// word that follows a write to the same address is forwarded around the RAM. The store
// needs no clearing pass after reset: a fill count marks the words written so far and all
// others read as all ones. Depends on cnbc_pkg and the cnbc_* modules.
`timescale 1ns / 1ps

module coverage_new_bits_check
    import cnbc_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [COV_W-1:0]       s_tdata,   // [63:0] coverage_word
    input  logic                   s_tlast,   // last_word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] verdict, [7:2] zero
);

    logic      push_valid, push_ready;
    cls_item_t push_item;
    logic      pop_valid, pop_ready;
    cls_item_t pop_item;

    cnbc_front #(
        .MAP_WORDS (MAP_WORDS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    cnbc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    cnbc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ hdl/cnbc_checker.sv @@
// Port-level checker for the coverage new-bits checker, bound to the top level.
// Depends on cnbc_pkg.
`timescale 1ns / 1ps

module cnbc_checker
    import cnbc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [COV_W-1:0]       s_tdata,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A shown verdict is a legal code with zero padding
    a_out_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[OUT_TDATA_W-1:2] == '0))
        else $error("illegal verdict on output");

    // An accepted input transaction carries known data
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown({s_tdata, s_tlast}))
        else $error("unknown data on accepted input");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind coverage_new_bits_check cnbc_checker u_checker (.*);
